// ----- hw/rtl/ihc_pkg.sv -----
// shared types, constants and codes for the ipv4 header check and classify block
`timescale 1ns / 1ps

package ihc_pkg;

  // depth of the queues between front, back and the result port
  localparam int unsigned QueueDepth = 2;

  // header layout, in 16-bit words from the start of the header
  localparam logic [4:0] WordVerIhl   = 5'd0;
  localparam logic [4:0] WordTotalLen = 5'd1;
  localparam logic [4:0] WordIdent    = 5'd2;
  localparam logic [4:0] WordFlagsOff = 5'd3;
  localparam logic [4:0] WordTtlProto = 5'd4;
  localparam logic [4:0] WordCsum     = 5'd5;
  localparam logic [4:0] WordSrcHi    = 5'd6;
  localparam logic [4:0] WordSrcLo    = 5'd7;
  localparam logic [4:0] WordDstHi    = 5'd8;
  localparam logic [4:0] WordDstLo    = 5'd9;

  // smallest legal header length in 32-bit words
  localparam logic [3:0] IhlMin = 4'd5;

  // protocol numbers
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  typedef enum logic [2:0] {
    VerdictBadCsum  = 3'd0,
    VerdictBadLen   = 3'd1,
    VerdictFragment = 3'd2,
    VerdictIcmp     = 3'd3,
    VerdictTcp      = 3'd4,
    VerdictUdp      = 3'd5,
    VerdictOther    = 3'd6
  } verdict_e;

  // one input item
  typedef struct packed {
    logic [15:0] header_word;
    logic        first_word;
  } in_item_t;

  // one result item
  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] ident;
    logic [15:0] payload_length;
    logic [12:0] fragment_offset;
    logic        more_fragments;
    logic        flush_reassembly;
  } result_t;

  // finished header as handed from front to back
  typedef struct packed {
    logic        bad_len;
    logic [20:0] sum;
    logic [15:0] rx_csum;
    logic [15:0] total_len;
    logic [15:0] ident;
    logic [15:0] flags_off;
    logic [7:0]  protocol;
    logic [31:0] src;
    logic [31:0] dst;
    logic [4:0]  hdr_words;
  } hdr_rec_t;

endpackage

// ----- hw/rtl/ipv4_header_check_classify.sv -----
// Top level of the ipv4 header check and classify block. Header words enter
// one per clock through the push side while full is low, first_word marking
// the start of each header; the front keeps the ones-complement sum in a
// 21-bit register and captures the fields, a short queue hands the finished
// header to the back, which folds the checksum, classifies the packet and
// queues one result item per completed header (or per header with IHL below
// five, right on its first word). A result passes through the header queue
// and then the result queue, both registered, before it is visible. full
// drops back only as the back drains the internal queue, so with pop held low
// the block keeps taking words until both queues hold QueueDepth headers each.
`timescale 1ns / 1ps

module ipv4_header_check_classify #(
  parameter int unsigned QueueDepth = ihc_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  ihc_pkg::in_item_t item_i,
  output logic              full,
  input  logic              pop,
  output ihc_pkg::result_t  result_o,
  output logic              empty
);

  localparam int unsigned RecW = $bits(ihc_pkg::hdr_rec_t);
  localparam int unsigned ResW = $bits(ihc_pkg::result_t);

  logic              accept;
  logic              rec_push, rec_full, rec_empty, rec_pop;
  ihc_pkg::hdr_rec_t rec_in, rec_out;
  logic              res_push, res_full;
  ihc_pkg::result_t  res_in;

  // input items are taken while the header queue has room
  assign full   = rec_full;
  assign accept = push && !rec_full;

  ihc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  // header queue between front and back
  ihc_fifo #(
    .Width (RecW),
    .Depth (QueueDepth)
  ) u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .data_o  (rec_out),
    .empty_o (rec_empty)
  );

  ihc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!rec_empty),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue on the output side
  ihc_fifo #(
    .Width (ResW),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

// ----- hw/rtl/ihc_fifo.sv -----
// small first-in first-out queue of fixed-width items
`timescale 1ns / 1ps

module ihc_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  // fill count stays in range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count out of range");

  // a lone push grows the queue by one item
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue did not grow on push");

  // a lone pop shrinks the queue by one item
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue did not shrink on pop");

endmodule

// ----- hw/rtl/ihc_front.sv -----
// front part: walks the header words, keeps the running sum and captures fields
`timescale 1ns / 1ps

module ihc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ihc_pkg::in_item_t item_i,
  output logic              rec_push_o,
  output ihc_pkg::hdr_rec_t rec_o
);

  logic        in_header_q, in_header_d;
  logic [4:0]  word_index_q, word_index_d;
  logic [4:0]  header_words_q, header_words_d;
  logic [20:0] sum_q, sum_d;
  logic [15:0] rx_csum_q, rx_csum_d;
  logic [15:0] total_len_q, total_len_d;
  logic [15:0] ident_q, ident_d;
  logic [15:0] flags_q, flags_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic        start, active, bad_len, last_word;
  logic [4:0]  idx;
  logic [15:0] w;
  logic [3:0]  ihl;

  assign w      = item_i.header_word;
  assign start  = item_i.first_word;
  assign active = start || in_header_q;
  assign idx    = start ? ihc_pkg::WordVerIhl : word_index_q;
  assign ihl    = w[11:8];

  // field capture and running sum for the current word
  always_comb begin
    header_words_d = start ? '0 : header_words_q;
    sum_d          = start ? '0 : sum_q;
    rx_csum_d      = start ? '0 : rx_csum_q;
    total_len_d    = start ? '0 : total_len_q;
    ident_d        = start ? '0 : ident_q;
    flags_d        = start ? '0 : flags_q;
    proto_d        = start ? '0 : proto_q;
    src_d          = start ? '0 : src_q;
    dst_d          = start ? '0 : dst_q;
    bad_len        = 1'b0;

    if (idx != ihc_pkg::WordCsum) begin
      sum_d = sum_d + {5'd0, w};
    end

    case (idx)
      ihc_pkg::WordVerIhl: begin
        if (ihl < ihc_pkg::IhlMin) begin
          bad_len = 1'b1;
        end
        header_words_d = {ihl, 1'b0};
      end
      ihc_pkg::WordTotalLen: total_len_d   = w;
      ihc_pkg::WordIdent:    ident_d       = w;
      ihc_pkg::WordFlagsOff: flags_d       = w;
      ihc_pkg::WordTtlProto: proto_d       = w[7:0];
      ihc_pkg::WordCsum:     rx_csum_d     = w;
      ihc_pkg::WordSrcHi:    src_d[31:16]  = w;
      ihc_pkg::WordSrcLo:    src_d[15:0]   = w;
      ihc_pkg::WordDstHi:    dst_d[31:16]  = w;
      ihc_pkg::WordDstLo:    dst_d[15:0]   = w;
      default: ;
    endcase
  end

  assign last_word = bad_len || (({1'b0, idx} + 6'd1) >= {1'b0, header_words_d});

  // header tracking
  always_comb begin
    in_header_d  = in_header_q;
    word_index_d = word_index_q;
    if (accept_i && active) begin
      in_header_d  = !last_word;
      word_index_d = last_word ? idx : idx + 5'd1;
    end
  end

  // finished header record
  always_comb begin
    rec_push_o = accept_i && active && last_word;
    rec_o      = '0;
    rec_o.bad_len = bad_len;
    if (!bad_len) begin
      rec_o.sum       = sum_d;
      rec_o.rx_csum   = rx_csum_d;
      rec_o.total_len = total_len_d;
      rec_o.ident     = ident_d;
      rec_o.flags_off = flags_d;
      rec_o.protocol  = proto_d;
      rec_o.src       = src_d;
      rec_o.dst       = dst_d;
      rec_o.hdr_words = header_words_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q    <= 1'b0;
      word_index_q   <= '0;
      header_words_q <= '0;
      sum_q          <= '0;
      rx_csum_q      <= '0;
      total_len_q    <= '0;
      ident_q        <= '0;
      flags_q        <= '0;
      proto_q        <= '0;
      src_q          <= '0;
      dst_q          <= '0;
    end else begin
      in_header_q  <= in_header_d;
      word_index_q <= word_index_d;
      if (accept_i && active) begin
        header_words_q <= header_words_d;
        sum_q          <= sum_d;
        rx_csum_q      <= rx_csum_d;
        total_len_q    <= total_len_d;
        ident_q        <= ident_d;
        flags_q        <= flags_d;
        proto_q        <= proto_d;
        src_q          <= src_d;
        dst_q          <= dst_d;
      end
    end
  end

endmodule

// ----- hw/rtl/ihc_back.sv -----
// back part: folds the checksum, classifies the header and forms the result item
`timescale 1ns / 1ps

module ihc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_valid_i,
  input  ihc_pkg::hdr_rec_t rec_i,
  output logic              rec_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output ihc_pkg::result_t  res_o
);

  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] calc_csum;
  logic [5:0]  hdr_bytes;
  logic        csum_ok, frag;

  // move one record per cycle while the result queue has room
  assign rec_pop_o  = rec_valid_i && !res_full_i;
  assign res_push_o = rec_pop_o;

  // ones-complement fold of the running sum
  assign fold1     = {12'd0, rec_i.sum[20:16]} + {1'b0, rec_i.sum[15:0]};
  assign fold2     = fold1[15:0] + {15'd0, fold1[16]};
  assign calc_csum = ~fold2;
  assign csum_ok   = (calc_csum == rec_i.rx_csum);
  assign frag      = (rec_i.flags_off[13:0] != '0);
  assign hdr_bytes = {rec_i.hdr_words, 1'b0};

  // verdict and result fields
  always_comb begin
    res_o = '0;
    if (rec_i.bad_len) begin
      res_o.verdict = ihc_pkg::VerdictBadLen;
    end else begin
      res_o.protocol        = rec_i.protocol;
      res_o.source_address  = rec_i.src;
      res_o.dest_address    = rec_i.dst;
      res_o.ident           = rec_i.ident;
      res_o.fragment_offset = rec_i.flags_off[12:0];
      res_o.more_fragments  = rec_i.flags_off[13];
      if (rec_i.total_len >= {10'd0, hdr_bytes}) begin
        res_o.payload_length = rec_i.total_len - {10'd0, hdr_bytes};
      end
      if (!csum_ok) begin
        res_o.verdict = ihc_pkg::VerdictBadCsum;
      end else if (frag) begin
        res_o.verdict = ihc_pkg::VerdictFragment;
      end else begin
        res_o.flush_reassembly = 1'b1;
        case (rec_i.protocol)
          ihc_pkg::ProtoIcmp: res_o.verdict = ihc_pkg::VerdictIcmp;
          ihc_pkg::ProtoTcp:  res_o.verdict = ihc_pkg::VerdictTcp;
          ihc_pkg::ProtoUdp:  res_o.verdict = ihc_pkg::VerdictUdp;
          default:            res_o.verdict = ihc_pkg::VerdictOther;
        endcase
      end
    end
  end

  // flush is raised only for a deliverable packet
  a_flush_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.flush_reassembly) |->
      (res_o.verdict == ihc_pkg::VerdictIcmp || res_o.verdict == ihc_pkg::VerdictTcp ||
       res_o.verdict == ihc_pkg::VerdictUdp || res_o.verdict == ihc_pkg::VerdictOther))
    else $error("flush raised on a packet that is not delivered");

  // payload length never exceeds the total length
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_o.payload_length <= rec_i.total_len))
    else $error("payload length above total length");

  // a short header length gives a bare bad-length item
  a_bad_len_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && rec_i.bad_len) |->
      (res_o.verdict == ihc_pkg::VerdictBadLen && !res_o.flush_reassembly))
    else $error("bad-length item carries a wrong verdict or flush");

endmodule

// ----- dv/ipv4_header_check_classify_tb.sv -----
// testbench for the ipv4 header check and classify block
`timescale 1ns / 1ps

module ipv4_header_check_classify_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReported = 10;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  ihc_pkg::in_item_t item_i = '0;
  logic              full;
  logic              pop = 1'b0;
  ihc_pkg::result_t  result_o;
  logic              empty;

  // sender idle chance per item and receiver stall rate, in percent
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  // long receiver hold-off, requested by a test and counted by the pop process
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  int unsigned cycle_cnt = 0;
  int unsigned err_count = 0;
  int unsigned words_used = 0;

  // verdicts expected from the block, oldest first
  ihc_pkg::result_t expected_results[$];
  ihc_pkg::result_t want;
  // header under construction for the sender
  logic [15:0] pkt_words[$];
  logic [15:0] dir_hdr[10];

  // predictor state for the header being parsed
  logic        hdr_open = 1'b0;
  logic [4:0]  word_idx = '0;
  logic [4:0]  hdr_len_words = '0;
  logic [20:0] ones_sum = '0;
  logic [15:0] csum_rx = '0;
  logic [15:0] tot_len = '0;
  logic [15:0] ident_q = '0;
  logic [15:0] flags_q = '0;
  logic [7:0]  proto_q = '0;
  logic [31:0] src_q = '0;
  logic [31:0] dst_q = '0;

  ihc_pkg::verdict_e hdr_classes[6] = '{ihc_pkg::VerdictBadCsum, ihc_pkg::VerdictFragment,
                                        ihc_pkg::VerdictIcmp, ihc_pkg::VerdictTcp,
                                        ihc_pkg::VerdictUdp, ihc_pkg::VerdictOther};

  ipv4_header_check_classify dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .item_i  (item_i),
    .full    (full),
    .pop     (pop),
    .result_o(result_o),
    .empty   (empty)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run timeout
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("ipv4_header_check_classify_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // compare each popped result with the oldest expected verdict
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= MaxReported)
          $display("unexpected result at cycle %0d: verdict %0d", cycle_cnt, result_o.verdict);
      end else begin
        want = expected_results.pop_front();
        if (want.verdict !== result_o.verdict || want.protocol !== result_o.protocol ||
            want.source_address !== result_o.source_address ||
            want.dest_address !== result_o.dest_address || want.ident !== result_o.ident ||
            want.payload_length !== result_o.payload_length ||
            want.fragment_offset !== result_o.fragment_offset ||
            want.more_fragments !== result_o.more_fragments ||
            want.flush_reassembly !== result_o.flush_reassembly) begin
          err_count++;
          if (err_count <= MaxReported) begin
            $display("result mismatch at cycle %0d", cycle_cnt);
            $display("  exp verdict %0d proto %h src %h dst %h id %h len %h off %h mf %b fl %b",
                     want.verdict, want.protocol, want.source_address, want.dest_address,
                     want.ident, want.payload_length, want.fragment_offset,
                     want.more_fragments, want.flush_reassembly);
            $display("  got verdict %0d proto %h src %h dst %h id %h len %h off %h mf %b fl %b",
                     result_o.verdict, result_o.protocol, result_o.source_address,
                     result_o.dest_address, result_o.ident, result_o.payload_length,
                     result_o.fragment_offset, result_o.more_fragments,
                     result_o.flush_reassembly);
          end
        end
      end
    end
  end

  // fold the running sum and classify the finished header
  task automatic classify_header();
    ihc_pkg::result_t r;
    logic [16:0] fold;
    logic [15:0] calc;
    logic [5:0]  hdr_bytes;
    r = '0;
    fold = {1'b0, ones_sum[15:0]} + {12'b0, ones_sum[20:16]};
    fold = fold + {16'b0, fold[16]};
    calc = ~fold[15:0];
    hdr_bytes = {hdr_len_words, 1'b0};
    if (calc != csum_rx) begin
      r.verdict = ihc_pkg::VerdictBadCsum;
    end else if (flags_q[13:0] != 14'd0) begin
      r.verdict = ihc_pkg::VerdictFragment;
    end else begin
      r.flush_reassembly = 1'b1;
      if (proto_q == ihc_pkg::ProtoIcmp) r.verdict = ihc_pkg::VerdictIcmp;
      else if (proto_q == ihc_pkg::ProtoTcp) r.verdict = ihc_pkg::VerdictTcp;
      else if (proto_q == ihc_pkg::ProtoUdp) r.verdict = ihc_pkg::VerdictUdp;
      else r.verdict = ihc_pkg::VerdictOther;
    end
    r.protocol = proto_q;
    r.source_address = src_q;
    r.dest_address = dst_q;
    r.ident = ident_q;
    r.payload_length = (tot_len >= {10'b0, hdr_bytes}) ? tot_len - {10'b0, hdr_bytes} : 16'd0;
    r.fragment_offset = flags_q[12:0];
    r.more_fragments = flags_q[13];
    expected_results.push_back(r);
  endtask

  // predictor: advance the header parse by one accepted item
  task automatic predict_word(input logic [15:0] w, input logic first);
    ihc_pkg::result_t r;
    logic [4:0] idx;
    if (first) begin
      word_idx = '0;
      hdr_len_words = '0;
      ones_sum = '0;
      csum_rx = '0;
      tot_len = '0;
      ident_q = '0;
      flags_q = '0;
      proto_q = '0;
      src_q = '0;
      dst_q = '0;
      hdr_open = 1'b1;
    end
    if (hdr_open) begin
      words_used++;
      idx = word_idx;
      // checksum word counts as zero
      if (idx != ihc_pkg::WordCsum) ones_sum = ones_sum + {5'b0, w};
      case (idx)
        ihc_pkg::WordVerIhl:   hdr_len_words = {w[11:8], 1'b0};
        ihc_pkg::WordTotalLen: tot_len = w;
        ihc_pkg::WordIdent:    ident_q = w;
        ihc_pkg::WordFlagsOff: flags_q = w;
        ihc_pkg::WordTtlProto: proto_q = w[7:0];
        ihc_pkg::WordCsum:     csum_rx = w;
        ihc_pkg::WordSrcHi:    src_q[31:16] = w;
        ihc_pkg::WordSrcLo:    src_q[15:0] = w;
        ihc_pkg::WordDstHi:    dst_q[31:16] = w;
        ihc_pkg::WordDstLo:    dst_q[15:0] = w;
        default: ;
      endcase
      if (idx == ihc_pkg::WordVerIhl && w[11:8] < ihc_pkg::IhlMin) begin
        // short header length: verdict at once, all else zero
        r = '0;
        r.verdict = ihc_pkg::VerdictBadLen;
        expected_results.push_back(r);
        hdr_open = 1'b0;
      end else if ({1'b0, idx} + 6'd1 >= {1'b0, hdr_len_words}) begin
        classify_header();
        hdr_open = 1'b0;
      end else begin
        word_idx = idx + 5'd1;
      end
    end
  endtask

  // offer one item, with a random idle gap before it
  task automatic send_word(input logic [15:0] w, input logic first);
    int unsigned gap;
    ihc_pkg::in_item_t it;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(4, 1);
    if (gap != 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    it.header_word = w;
    it.first_word = first;
    @(negedge clk_i);
    push <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_word(w, first);
  endtask

  // send the first n words of the built header
  task automatic send_pkt(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(pkt_words[i], (i == 0));
  endtask

  // fill in the header checksum, optionally corrupted
  task automatic fill_csum(input bit corrupt);
    logic [31:0] acc;
    logic [15:0] c;
    acc = '0;
    foreach (pkt_words[i]) if (i != ihc_pkg::WordCsum) acc += {16'b0, pkt_words[i]};
    acc = {16'b0, acc[15:0]} + {16'b0, acc[31:16]};
    acc = {16'b0, acc[15:0]} + {16'b0, acc[31:16]};
    c = ~acc[15:0];
    if (corrupt) c = c ^ 16'($urandom_range(16'hffff, 1));
    pkt_words[ihc_pkg::WordCsum] = c;
  endtask

  // build a header aimed at one verdict
  task automatic make_header(input ihc_pkg::verdict_e cls);
    int unsigned ihl;
    logic [3:0]  ver;
    logic [15:0] len;
    logic [15:0] flags;
    logic [7:0]  proto;
    ihl = ($urandom_range(9) < 7) ? 5 : $urandom_range(15, 6);
    ver = ($urandom_range(9) < 8) ? 4'd4 : 4'($urandom);
    case ($urandom_range(3))
      0, 1: len = 16'($urandom);
      2: len = 16'($urandom_range(ihl * 4));
      default: len = 16'(ihl * 4 + $urandom_range(64));
    endcase
    if (cls == ihc_pkg::VerdictFragment) begin
      flags = 16'($urandom);
      if ($urandom_range(1)) flags[12:0] = '0;
      if (flags[13:0] == 14'd0) flags[13] = 1'b1;
    end else if (cls == ihc_pkg::VerdictBadCsum) begin
      flags = $urandom_range(1) ? 16'($urandom) : {2'($urandom), 14'd0};
    end else begin
      flags = {2'($urandom), 14'd0};
    end
    case (cls)
      ihc_pkg::VerdictIcmp: proto = ihc_pkg::ProtoIcmp;
      ihc_pkg::VerdictTcp:  proto = ihc_pkg::ProtoTcp;
      ihc_pkg::VerdictUdp:  proto = ihc_pkg::ProtoUdp;
      ihc_pkg::VerdictOther: begin
        proto = 8'($urandom);
        while (proto == ihc_pkg::ProtoIcmp || proto == ihc_pkg::ProtoTcp ||
               proto == ihc_pkg::ProtoUdp)
          proto = 8'($urandom);
      end
      default: begin
        case ($urandom_range(3))
          0: proto = ihc_pkg::ProtoIcmp;
          1: proto = ihc_pkg::ProtoTcp;
          2: proto = ihc_pkg::ProtoUdp;
          default: proto = 8'($urandom);
        endcase
      end
    endcase
    pkt_words.delete();
    pkt_words.push_back({ver, 4'(ihl), 8'($urandom)});
    pkt_words.push_back(len);
    pkt_words.push_back(16'($urandom));
    pkt_words.push_back(flags);
    pkt_words.push_back({8'($urandom), proto});
    pkt_words.push_back(16'h0000);
    // addresses and options
    for (int unsigned i = 6; i < ihl * 2; i++) pkt_words.push_back(16'($urandom));
    fill_csum(cls == ihc_pkg::VerdictBadCsum);
  endtask

  // directed: short lengths, stray word, extreme fields, restart mid-header
  task automatic test_directed();
    send_word(16'h4400, 1'b1);
    send_word(16'h0000, 1'b1);
    send_word(16'hffff, 1'b0);
    // udp, all-ones fields, zero payload
    dir_hdr = '{16'h45ff, 16'h0014, 16'hffff, 16'h4000, 16'hff11,
                16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'h0000};
    pkt_words.delete();
    foreach (dir_hdr[i]) pkt_words.push_back(dir_hdr[i]);
    fill_csum(1'b0);
    send_pkt(10);
    // header dropped after two words
    send_word(16'h4f00, 1'b1);
    send_word(16'habcd, 1'b0);
    // fragment with max offset and more-fragments, payload saturates at zero
    dir_hdr = '{16'h4500, 16'h0000, 16'h0000, 16'h3fff, 16'h0000,
                16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff};
    pkt_words.delete();
    foreach (dir_hdr[i]) pkt_words.push_back(dir_hdr[i]);
    fill_csum(1'b0);
    send_pkt(10);
  endtask

  // random traffic, mostly complete headers
  task automatic test_random(input int unsigned n_words, input int unsigned s_pct,
                             input int unsigned r_pct);
    int unsigned target;
    int unsigned n;
    send_idle_pct = s_pct;
    pop_stall_pct = r_pct;
    target = words_used + n_words;
    while (words_used < target) begin
      case ($urandom_range(9))
        0: send_word({4'($urandom), 4'($urandom_range(4)), 8'($urandom)}, 1'b1);
        1: begin
          n = $urandom_range(3, 1);
          repeat (n) send_word(16'($urandom), 1'b0);
        end
        2: begin
          make_header(hdr_classes[$urandom_range(5)]);
          send_pkt($urandom_range(pkt_words.size() - 1, 1));
        end
        3: begin
          send_word(16'($urandom), 1'b1);
          n = $urandom_range(12);
          repeat (n) send_word(16'($urandom), 1'b0);
        end
        default: begin
          make_header(hdr_classes[$urandom_range(5)]);
          send_pkt(pkt_words.size());
        end
      endcase
    end
  endtask

  // receiver holds off while headers keep coming, so the block fills up
  task automatic test_backpressure();
    int unsigned target;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    @(posedge clk_i);
    hold_req = 300;
    target = words_used + 150;
    while (words_used < target) begin
      make_header(hdr_classes[$urandom_range(5)]);
      send_pkt(pkt_words.size());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 63, 0);
    test_random(300, 0, 63);
    test_random(300, 25, 25);
    test_backpressure();
    // drain
    send_idle_pct = 0;
    pop_stall_pct = 0;
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("ipv4_header_check_classify_tb: done, clean");
    end else begin
      $display("ipv4_header_check_classify_tb: done, errors");
    end
    $finish;
  end

endmodule
